### design/crossing_signal_grouper_assert.svh
`ifndef CROSSING_SIGNAL_GROUPER_ASSERT_SVH
`define CROSSING_SIGNAL_GROUPER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CSG_ASSERT_HOLDS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define CSG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### design/csg_pkg.sv
package csg_pkg;

   localparam int DEF_MAX_SIGNALS = 256;
   localparam int DEF_MASK_BITS   = 32;
   localparam int MASK_MAX        = 63;
   localparam int SCORE_W         = 6;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_LOAD    = 2'd1,
      REQ_COMPUTE = 2'd2,
      REQ_READ    = 2'd3
   } req_kind_type;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FULL       = 3'd1;
   localparam logic [2:0] ST_ZERO_RATIO = 3'd2;
   localparam logic [2:0] ST_EMPTY      = 3'd3;
   localparam logic [2:0] ST_BAD_READ   = 3'd4;

   localparam logic [1:0] CLS_EQUAL  = 2'd0;
   localparam logic [1:0] CLS_SUBSET = 2'd1;
   localparam logic [1:0] CLS_OTHER  = 2'd2;

   typedef struct packed {
      logic [1:0]         cls;
      logic [SCORE_W-1:0] diff;
      logic [SCORE_W-1:0] pop;
   } score_type;

   function automatic logic [SCORE_W-1:0] pop_count(input logic [MASK_MAX-1:0] v);
      logic [SCORE_W-1:0] n;
      n = '0;
      for (int k = 0; k < MASK_MAX; k++) begin
         n = n + SCORE_W'(v[k]);
      end
      return n;
   endfunction

   // Lower class first, then fewer differing bits, then more set bits.
   function automatic logic score_better(input score_type a, input score_type b);
      logic r;
      if (a.cls != b.cls) begin
         r = (a.cls < b.cls);
      end else if (a.diff != b.diff) begin
         r = (a.diff < b.diff);
      end else begin
         r = (a.pop > b.pop);
      end
      return r;
   endfunction

endpackage

### design/csg_ifs.sv
interface csg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  signal_domain;
   logic [7:0]  signal_ratio;
   logic [31:0] signal_encoding;
   logic [7:0]  query_index;

   modport source(output valid, req_type, signal_domain, signal_ratio, signal_encoding,
                  query_index, input ready);
   modport sink(input valid, req_type, signal_domain, signal_ratio, signal_encoding,
                query_index, output ready);
endinterface

interface csg_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  signal_index;
   logic [7:0]  group_num;
   logic [8:0]  group_count;
   logic [13:0] cross_total;

   modport source(output valid, status, signal_index, group_num, group_count, cross_total,
                  input ready);
   modport sink(input valid, status, signal_index, group_num, group_count, cross_total,
                output ready);
endinterface

### design/csg_score.sv
module csg_score import csg_pkg::*; #(
   parameter int MASK_BITS = DEF_MASK_BITS
) (
   input  logic [MASK_BITS-1:0] cand_mask,
   input  logic [MASK_BITS-1:0] target_mask,
   output score_type            score
);

   logic [MASK_MAX-1:0] cand_w;
   logic [MASK_MAX-1:0] diff_w;

   assign cand_w = MASK_MAX'(cand_mask);
   assign diff_w = MASK_MAX'(cand_mask ^ target_mask);

   always_comb begin
      score.pop = pop_count(cand_w);
      if (cand_mask == target_mask) begin
         score.cls  = CLS_EQUAL;
         score.diff = '0;
      end else if ((cand_mask | target_mask) == target_mask) begin
         score.cls  = CLS_SUBSET;
         score.diff = '0;
      end else begin
         score.cls  = CLS_OTHER;
         score.diff = pop_count(diff_w);
      end
   end

endmodule

### design/crossing_signal_grouper.sv
// Crossing signal grouper. Each request item gives exactly one response item. Clear, load and
// a rejected request go from the execute state straight to the done state; a read passes
// through the read state between them. Compute walks the two signal memories, which share
// one read address: one pass over the loaded signals to find the next bucket, one pass to
// seed each group, and for every pick one pass to score the candidates, one entry-by-entry
// pass (a read state and a wait state per entry) to find the tied ones, and one further full
// pass for each tied candidate whose mask differs from the current best to count how many of
// that mask remain. A signal counts as taken when the flag stored beside its group number
// matches the epoch of the current compute, so no clearing pass is needed. The block takes a
// new item only when the previous one is finished; a finished response waits in the output
// register.
`include "crossing_signal_grouper_assert.svh"

module crossing_signal_grouper import csg_pkg::*; #(
   parameter int MAX_SIGNALS = DEF_MAX_SIGNALS,
   parameter int MASK_BITS   = DEF_MASK_BITS
) (
   input logic       clock,
   input logic       reset,
   csg_req_if.sink   req_chan,
   csg_rsp_if.source rsp_chan
);

   localparam int IDX_W  = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;
   localparam int CNT_W  = $clog2(MAX_SIGNALS + 1);
   localparam int ENT_W  = 16 + MASK_BITS;
   localparam int BITS_W = CNT_W + SCORE_W;

   typedef enum logic [13:0] {
      S_IDLE    = 14'h0001,
      S_EXEC    = 14'h0002,
      S_READ    = 14'h0004,
      S_BKT     = 14'h0008,
      S_SEED    = 14'h0010,
      S_PA      = 14'h0020,
      S_PB_RD   = 14'h0040,
      S_PB_WT   = 14'h0080,
      S_CNT     = 14'h0100,
      S_PB_CMP  = 14'h0200,
      S_COMMIT  = 14'h0400,
      S_CLOSE   = 14'h0800,
      S_FIN     = 14'h1000,
      S_DONE    = 14'h2000
   } state_type;

   // Memories
   logic [ENT_W-1:0] ent_mem [MAX_SIGNALS];
   logic [8:0]       grp_mem [MAX_SIGNALS];
   logic [ENT_W-1:0] ent_rd_ff;
   logic [8:0]       grp_rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             ent_we;
   logic             grp_we;
   logic [IDX_W-1:0] grp_wr_addr;
   logic [8:0]       grp_wr_data;

   // Control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [8:0]         groups_ff, groups_in;
   logic [13:0]        bits_ff, bits_in;
   logic               results_ready_ff, results_ready_in;
   logic               epoch_ff, epoch_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               lag_vld_ff;

   // Request and working registers
   req_kind_type       rq_kind_ff;
   logic [7:0]         rq_dom_ff, rq_rat_ff, rq_q_ff;
   logic [31:0]        rq_enc_ff;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   lag_idx_ff;
   logic               found_ff, found_in;
   logic               have_ff, have_in;
   logic [15:0]        bkey_ff, bkey_in;
   logic [SCORE_W-1:0] spop_ff, spop_in;
   logic [MASK_BITS-1:0] target_ff, target_in;
   logic [8:0]         size_ff, size_in;
   score_type          best_sc_ff, best_sc_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [MASK_BITS-1:0] best_mask_ff, best_mask_in;
   logic [CNT_W-1:0]   best_n_ff, best_n_in;
   logic [IDX_W-1:0]   cand_idx_ff, cand_idx_in;
   logic [MASK_BITS-1:0] cand_mask_ff, cand_mask_in;
   logic [CNT_W-1:0]   cnt_n_ff, cnt_n_in;
   logic [CNT_W-1:0]   outer_ff, outer_in;
   logic [CNT_W-1:0]   grp_acc_ff, grp_acc_in;
   logic [BITS_W-1:0]  bit_acc_ff, bit_acc_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [7:0]         res_sidx_ff, res_sidx_in;
   logic [7:0]         res_gid_ff, res_gid_in;
   logic [2:0]         o_status_ff;
   logic [7:0]         o_sidx_ff, o_gid_ff;
   logic [8:0]         o_gcnt_ff;
   logic [13:0]        o_bits_ff;

   // Decoded read data and helpers
   logic [15:0]          e_key;
   logic [MASK_BITS-1:0] e_mask;
   logic                 e_open;
   score_type            sc;
   logic                 in_scan, issue, scan_end;
   logic                 live_any, live_bkt, pb_live;
   logic                 out_free, req_fire;
   logic [IDX_W+7:0]     q_wide;
   logic                 q_bad;
   logic [CNT_W+7:0]     loaded_w;
   logic [CNT_W+7:0]     grp_acc_w;
   logic [CNT_W+8:0]     grp_sat_w;
   logic [BITS_W+13:0]   bit_sat_w;
   logic [MASK_BITS+31:0] enc_w;
   logic [CNT_W-1:0]     outer_nx;
   logic [SCORE_W-1:0]   target_pop;

   assign e_key  = ent_rd_ff[ENT_W-1:MASK_BITS];
   assign e_mask = ent_rd_ff[MASK_BITS-1:0];
   assign e_open = (grp_rd_ff[8] != epoch_ff);

   csg_score #(.MASK_BITS(MASK_BITS)) u_score (
      .cand_mask   (e_mask),
      .target_mask (target_ff),
      .score       (sc)
   );

   assign in_scan  = (state_ff == S_BKT) || (state_ff == S_SEED) ||
                     (state_ff == S_PA) || (state_ff == S_CNT);
   assign issue    = in_scan && (ptr_ff != loaded_ff);
   assign scan_end = in_scan && (ptr_ff == loaded_ff) && !lag_vld_ff;
   assign live_any = lag_vld_ff && e_open;
   assign live_bkt = live_any && (e_key == bkey_ff);
   assign pb_live  = e_open && (e_key == bkey_ff);

   assign q_wide    = {{IDX_W{1'b0}}, rq_q_ff};
   assign q_bad     = !results_ready_ff ||
                      ({1'b0, q_wide} >= (IDX_W+9)'(loaded_ff));
   assign loaded_w  = (CNT_W+8)'(loaded_ff);
   assign grp_acc_w = (CNT_W+8)'(grp_acc_ff);
   assign grp_sat_w = (CNT_W+9)'(grp_acc_ff);
   assign bit_sat_w = (BITS_W+14)'(bit_acc_ff);
   assign enc_w     = {{MASK_BITS{1'b0}}, rq_enc_ff};
   assign outer_nx  = outer_ff + CNT_W'(1);
   assign target_pop = pop_count(MASK_MAX'(target_ff));

   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      if (state_ff == S_EXEC) begin
         rd_addr = q_wide[IDX_W-1:0];
      end else if (state_ff == S_PB_RD) begin
         rd_addr = outer_ff[IDX_W-1:0];
      end else begin
         rd_addr = ptr_ff[IDX_W-1:0];
      end
   end

   assign ent_we = (state_ff == S_EXEC) && (rq_kind_ff == REQ_LOAD) &&
                   (loaded_ff != CNT_W'(MAX_SIGNALS)) && (rq_rat_ff != 8'd0);
   assign grp_we = (state_ff == S_COMMIT) || ent_we;

   // A new signal is stamped with the current epoch, so the next compute sees it as open.
   assign grp_wr_addr = ent_we ? loaded_ff[IDX_W-1:0] : best_idx_ff;
   assign grp_wr_data = ent_we ? {epoch_ff, 8'd0} : {epoch_ff, grp_acc_w[7:0]};

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[loaded_ff[IDX_W-1:0]] <= {rq_dom_ff, rq_rat_ff, enc_w[MASK_BITS-1:0]};
      end
      ent_rd_ff <= ent_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[grp_wr_addr] <= grp_wr_data;
      end
      grp_rd_ff <= grp_mem[rd_addr];
   end

   always_comb begin
      state_in         = state_ff;
      loaded_in        = loaded_ff;
      groups_in        = groups_ff;
      bits_in          = bits_ff;
      results_ready_in = results_ready_ff;
      epoch_in         = epoch_ff;
      rsp_vld_in       = rsp_vld_ff && !rsp_chan.ready;
      ptr_in           = issue ? (ptr_ff + CNT_W'(1)) : ptr_ff;
      found_in         = found_ff;
      have_in          = have_ff;
      bkey_in          = bkey_ff;
      spop_in          = spop_ff;
      target_in        = target_ff;
      size_in          = size_ff;
      best_sc_in       = best_sc_ff;
      best_idx_in      = best_idx_ff;
      best_mask_in     = best_mask_ff;
      best_n_in        = best_n_ff;
      cand_idx_in      = cand_idx_ff;
      cand_mask_in     = cand_mask_ff;
      cnt_n_in         = cnt_n_ff;
      outer_in         = outer_ff;
      grp_acc_in       = grp_acc_ff;
      bit_acc_in       = bit_acc_ff;
      res_status_in    = res_status_ff;
      res_sidx_in      = res_sidx_ff;
      res_gid_in       = res_gid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = ST_OK;
            res_sidx_in   = 8'd0;
            res_gid_in    = 8'd0;
            state_in      = S_DONE;
            unique case (rq_kind_ff)
               REQ_CLEAR: begin
                  loaded_in        = '0;
                  results_ready_in = 1'b0;
                  groups_in        = '0;
                  bits_in          = '0;
               end
               REQ_LOAD: begin
                  if (loaded_ff == CNT_W'(MAX_SIGNALS)) begin
                     res_status_in = ST_FULL;
                  end else if (rq_rat_ff == 8'd0) begin
                     res_status_in = ST_ZERO_RATIO;
                  end else begin
                     res_sidx_in      = loaded_w[7:0];
                     loaded_in        = loaded_ff + CNT_W'(1);
                     results_ready_in = 1'b0;
                     groups_in        = '0;
                     bits_in          = '0;
                  end
               end
               REQ_COMPUTE: begin
                  if (loaded_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     // Every stored signal was either taken under the old epoch or
                     // stamped with it on load, so flipping the epoch frees them all.
                     epoch_in   = !epoch_ff;
                     ptr_in     = '0;
                     found_in   = 1'b0;
                     grp_acc_in = '0;
                     bit_acc_in = '0;
                     state_in   = S_BKT;
                  end
               end
               REQ_READ: begin
                  res_sidx_in = rq_q_ff;
                  if (q_bad) begin
                     res_status_in = ST_BAD_READ;
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_READ: begin
            res_gid_in = grp_rd_ff[7:0];
            state_in   = S_DONE;
         end
         S_BKT: begin
            if (live_any && (!found_ff || (e_key < bkey_ff))) begin
               found_in = 1'b1;
               bkey_in  = e_key;
            end
            if (scan_end) begin
               ptr_in   = '0;
               found_in = 1'b0;
               state_in = found_ff ? S_SEED : S_FIN;
            end
         end
         S_SEED: begin
            if (live_bkt && (!found_ff || (sc.pop > spop_ff) ||
                             ((sc.pop == spop_ff) && (e_mask > target_ff)))) begin
               found_in  = 1'b1;
               spop_in   = sc.pop;
               target_in = e_mask;
            end
            if (scan_end) begin
               ptr_in   = '0;
               found_in = 1'b0;
               size_in  = '0;
               state_in = found_ff ? S_PA : S_BKT;
            end
         end
         S_PA: begin
            if (live_bkt && (!found_ff || score_better(sc, best_sc_ff))) begin
               found_in   = 1'b1;
               best_sc_in = sc;
            end
            if (scan_end) begin
               found_in = 1'b0;
               outer_in = '0;
               have_in  = 1'b0;
               state_in = found_ff ? S_PB_RD : S_CLOSE;
            end
         end
         S_PB_RD: begin
            state_in = S_PB_WT;
         end
         S_PB_WT: begin
            // Only the candidates tied on the score go on to the count of equal masks;
            // a mask equal to the current best can never beat it.
            if (pb_live && (sc == best_sc_ff) && !(have_ff && (e_mask == best_mask_ff))) begin
               cand_mask_in = e_mask;
               cand_idx_in  = outer_ff[IDX_W-1:0];
               cnt_n_in     = '0;
               ptr_in       = '0;
               state_in     = S_CNT;
            end else begin
               outer_in = outer_nx;
               state_in = (outer_nx == loaded_ff) ? S_COMMIT : S_PB_RD;
            end
         end
         S_CNT: begin
            if (live_bkt && (e_mask == cand_mask_ff)) begin
               cnt_n_in = cnt_n_ff + CNT_W'(1);
            end
            if (scan_end) begin
               state_in = S_PB_CMP;
            end
         end
         S_PB_CMP: begin
            if (!have_ff || (cnt_n_ff < best_n_ff) ||
                ((cnt_n_ff == best_n_ff) && (cand_mask_ff > best_mask_ff))) begin
               have_in      = 1'b1;
               best_n_in    = cnt_n_ff;
               best_mask_in = cand_mask_ff;
               best_idx_in  = cand_idx_ff;
            end
            outer_in = outer_nx;
            state_in = (outer_nx == loaded_ff) ? S_COMMIT : S_PB_RD;
         end
         S_COMMIT: begin
            // The group memory write in this state also marks the pick as taken.
            target_in = target_ff | best_mask_ff;
            size_in   = size_ff + 9'd1;
            ptr_in    = '0;
            found_in  = 1'b0;
            state_in  = ((size_ff + 9'd1) == 9'(bkey_ff[7:0])) ? S_CLOSE : S_PA;
         end
         S_CLOSE: begin
            bit_acc_in = bit_acc_ff + BITS_W'(target_pop);
            grp_acc_in = grp_acc_ff + CNT_W'(1);
            ptr_in     = '0;
            found_in   = 1'b0;
            state_in   = S_SEED;
         end
         S_FIN: begin
            groups_in        = (grp_sat_w > (CNT_W+9)'(511)) ? 9'd511 : grp_sat_w[8:0];
            bits_in          = (bit_sat_w > (BITS_W+14)'(16383)) ? 14'd16383 :
                               bit_sat_w[13:0];
            results_ready_in = 1'b1;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         loaded_ff        <= '0;
         groups_ff        <= '0;
         bits_ff          <= '0;
         results_ready_ff <= 1'b0;
         epoch_ff         <= 1'b0;
         rsp_vld_ff       <= 1'b0;
         lag_vld_ff       <= 1'b0;
      end else begin
         state_ff         <= state_in;
         loaded_ff        <= loaded_in;
         groups_ff        <= groups_in;
         bits_ff          <= bits_in;
         results_ready_ff <= results_ready_in;
         epoch_ff         <= epoch_in;
         rsp_vld_ff       <= rsp_vld_in;
         lag_vld_ff       <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rq_kind_ff <= req_kind_type'(req_chan.req_type);
         rq_dom_ff  <= req_chan.signal_domain;
         rq_rat_ff  <= req_chan.signal_ratio;
         rq_enc_ff  <= req_chan.signal_encoding;
         rq_q_ff    <= req_chan.query_index;
      end
      if ((state_ff == S_DONE) && out_free) begin
         o_status_ff <= res_status_ff;
         o_sidx_ff   <= res_sidx_ff;
         o_gid_ff    <= res_gid_ff;
         o_gcnt_ff   <= groups_ff;
         o_bits_ff   <= bits_ff;
      end
      lag_idx_ff    <= ptr_ff[IDX_W-1:0];
      ptr_ff        <= ptr_in;
      found_ff      <= found_in;
      have_ff       <= have_in;
      bkey_ff       <= bkey_in;
      spop_ff       <= spop_in;
      target_ff     <= target_in;
      size_ff       <= size_in;
      best_sc_ff    <= best_sc_in;
      best_idx_ff   <= best_idx_in;
      best_mask_ff  <= best_mask_in;
      best_n_ff     <= best_n_in;
      cand_idx_ff   <= cand_idx_in;
      cand_mask_ff  <= cand_mask_in;
      cnt_n_ff      <= cnt_n_in;
      outer_ff      <= outer_in;
      grp_acc_ff    <= grp_acc_in;
      bit_acc_ff    <= bit_acc_in;
      res_status_ff <= res_status_in;
      res_sidx_ff   <= res_sidx_in;
      res_gid_ff    <= res_gid_in;
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.status       = o_status_ff;
   assign rsp_chan.signal_index = o_sidx_ff;
   assign rsp_chan.group_num    = o_gid_ff;
   assign rsp_chan.group_count  = o_gcnt_ff;
   assign rsp_chan.cross_total  = o_bits_ff;

   `CSG_ASSERT_NEXT(a_rsp_hold, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid,
      "response item dropped while stalled")
   `CSG_ASSERT_HOLDS(a_load_bound, loaded_ff <= CNT_W'(MAX_SIGNALS),
      "signal count beyond the store depth")
   `CSG_ASSERT_HOLDS(a_group_room, (state_ff != S_PA) || (size_ff < 9'(bkey_ff[7:0])),
      "group filled past its ratio")
   `CSG_ASSERT_NEXT(a_accept_exec, req_fire, state_ff == S_EXEC, "accepted item not executed")

endmodule
